// File: design/q4se_pkg.sv
package q4se_pkg;

  localparam int WORD_BITS = 48;
  localparam int FRAC_BITS = 24;
  localparam int UW_BITS   = WORD_BITS - 1;
  localparam int OP_BITS   = WORD_BITS + 2;
  localparam int ACC_BITS  = 2 * OP_BITS;
  localparam int ADDR_BITS = 6;
  localparam int DATA_BITS = 64;
  localparam int LO_BITS   = OP_BITS / 2;
  localparam int HI_BITS   = OP_BITS - LO_BITS;
  localparam int PP_BITS   = 2 * (LO_BITS + 1);

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic        [UW_BITS-1:0]   uword_t;
  typedef logic signed [OP_BITS-1:0]   op_t;
  typedef logic signed [ACC_BITS-1:0]  acc_t;
  typedef logic signed [PP_BITS-1:0]   pp_word_t;

  // partial products of one operand pair: low halves unsigned, high halves signed
  typedef struct packed {
    pp_word_t ll;
    pp_word_t lh;
    pp_word_t hl;
    pp_word_t hh;
  } pp_t;

  typedef enum logic [2:0] {
    REG_HALF_WIDTH  = 3'd0,
    REG_HALF_HEIGHT = 3'd1,
    REG_INV_AREA    = 3'd2,
    REG_C_NORMAL    = 3'd3,
    REG_C_CROSS     = 3'd4,
    REG_C_SHEAR     = 3'd5
  } reg_idx_t;

  typedef struct packed {
    uword_t half_width;
    uword_t half_height;
    uword_t inv_four_area;
    word_t  c_normal;
    word_t  c_cross;
    word_t  c_shear;
  } cfg_t;

  localparam uword_t RST_HALF  = UW_BITS'(1) << FRAC_BITS;
  localparam uword_t RST_INV   = UW_BITS'(1) << (FRAC_BITS - 2);
  localparam word_t  RST_CN    = WORD_BITS'(1) << FRAC_BITS;
  localparam word_t  RST_CS    = WORD_BITS'(1) << (FRAC_BITS - 1);

  // four multiplies of at most 26x26 signed bits; each 50-bit operand is split into 25-bit low and high halves
  function automatic pp_t pmul(input op_t a, input op_t b);
    logic signed [LO_BITS:0]   al;
    logic signed [LO_BITS:0]   bl;
    logic signed [HI_BITS-1:0] ah;
    logic signed [HI_BITS-1:0] bh;
    pp_t p;
    al = $signed({1'b0, a[LO_BITS-1:0]});
    bl = $signed({1'b0, b[LO_BITS-1:0]});
    ah = a[OP_BITS-1:LO_BITS];
    bh = b[OP_BITS-1:LO_BITS];
    p.ll = PP_BITS'(al) * PP_BITS'(bl);
    p.lh = PP_BITS'(al) * PP_BITS'(bh);
    p.hl = PP_BITS'(ah) * PP_BITS'(bl);
    p.hh = PP_BITS'(ah) * PP_BITS'(bh);
    return p;
  endfunction

  // weight and add the partial products into the full product
  function automatic acc_t psum(input pp_t p);
    acc_t mid;
    mid = ACC_BITS'(p.lh) + ACC_BITS'(p.hl);
    return ACC_BITS'(p.ll) + (mid <<< LO_BITS) + (ACC_BITS'(p.hh) <<< (2 * LO_BITS));
  endfunction

  // round half up, drop fraction, saturate to word
  function automatic word_t rsat(input acc_t v);
    acc_t t;
    t = (v + (ACC_BITS'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
    if (&t[ACC_BITS-1:WORD_BITS-1] || ~|t[ACC_BITS-1:WORD_BITS-1]) begin
      return t[WORD_BITS-1:0];
    end else if (t[ACC_BITS-1]) begin
      return {1'b1, {(WORD_BITS-1){1'b0}}};
    end else begin
      return {1'b0, {(WORD_BITS-1){1'b1}}};
    end
  endfunction

endpackage

// File: design/q4se_cfg.sv
module q4se_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [q4se_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [q4se_pkg::DATA_BITS-1:0]  pwdata,
  output logic [q4se_pkg::DATA_BITS-1:0]  prdata,
  output logic                            pready,
  output q4se_pkg::cfg_t                  cfg
);

  logic wr;
  q4se_pkg::reg_idx_t idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = q4se_pkg::reg_idx_t'(paddr[q4se_pkg::ADDR_BITS-1:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.half_width    <= q4se_pkg::RST_HALF;
      cfg.half_height   <= q4se_pkg::RST_HALF;
      cfg.inv_four_area <= q4se_pkg::RST_INV;
      cfg.c_normal      <= q4se_pkg::RST_CN;
      cfg.c_cross       <= '0;
      cfg.c_shear       <= q4se_pkg::RST_CS;
    end else if (wr) begin
      unique case (idx)
        q4se_pkg::REG_HALF_WIDTH:  cfg.half_width    <= pwdata[q4se_pkg::UW_BITS-1:0];
        q4se_pkg::REG_HALF_HEIGHT: cfg.half_height   <= pwdata[q4se_pkg::UW_BITS-1:0];
        q4se_pkg::REG_INV_AREA:    cfg.inv_four_area <= pwdata[q4se_pkg::UW_BITS-1:0];
        q4se_pkg::REG_C_NORMAL:    cfg.c_normal      <= pwdata[q4se_pkg::WORD_BITS-1:0];
        q4se_pkg::REG_C_CROSS:     cfg.c_cross       <= pwdata[q4se_pkg::WORD_BITS-1:0];
        q4se_pkg::REG_C_SHEAR:     cfg.c_shear       <= pwdata[q4se_pkg::WORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      q4se_pkg::REG_HALF_WIDTH:  prdata = q4se_pkg::DATA_BITS'(cfg.half_width);
      q4se_pkg::REG_HALF_HEIGHT: prdata = q4se_pkg::DATA_BITS'(cfg.half_height);
      q4se_pkg::REG_INV_AREA:    prdata = q4se_pkg::DATA_BITS'(cfg.inv_four_area);
      q4se_pkg::REG_C_NORMAL:    prdata = q4se_pkg::DATA_BITS'(cfg.c_normal);
      q4se_pkg::REG_C_CROSS:     prdata = q4se_pkg::DATA_BITS'(cfg.c_cross);
      q4se_pkg::REG_C_SHEAR:     prdata = q4se_pkg::DATA_BITS'(cfg.c_shear);
      default: prdata = '0;
    endcase
  end

endmodule

// File: design/quad4_point_stress_eval_top.sv
// Channel   Handshake             Payload
// request   start / busy          x_pos, y_pos, u1_x .. u4_y
// result    done (one cycle)      disp_*, strain_*, stress_*, outside
// config    APB psel/penable      paddr (8*index), pwdata/prdata 64 bit
//
// Seven register stages; a request accepted at one edge passes through stages 1
// to 6 and its result is registered at the outputs in stage 7.
// One request per cycle; busy is always low since every stage advances each cycle.
// Depth is set by three product levels (scaled offsets, shape functions and
// strains, displacement and stress), each split into a 26x26 partial-product
// stage and a sum/round/saturate stage, behind the edge-offset stage.
// rst (sync, active high) clears valid bits and restores register defaults.
// The receiver cannot stall: done is a one-cycle strobe.
module quad4_point_stress_eval_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [47:0]              x_pos,
  input  logic signed [47:0]              y_pos,
  input  logic signed [47:0]              u1_x,
  input  logic signed [47:0]              u1_y,
  input  logic signed [47:0]              u2_x,
  input  logic signed [47:0]              u2_y,
  input  logic signed [47:0]              u3_x,
  input  logic signed [47:0]              u3_y,
  input  logic signed [47:0]              u4_x,
  input  logic signed [47:0]              u4_y,
  output logic                            done,
  output logic signed [47:0]              disp_x,
  output logic signed [47:0]              disp_y,
  output logic signed [47:0]              strain_x,
  output logic signed [47:0]              strain_y,
  output logic signed [47:0]              strain_xy,
  output logic signed [47:0]              stress_x,
  output logic signed [47:0]              stress_y,
  output logic signed [47:0]              stress_xy,
  output logic                            outside,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [q4se_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [q4se_pkg::DATA_BITS-1:0]  pwdata,
  output logic [q4se_pkg::DATA_BITS-1:0]  prdata,
  output logic                            pready
);

  localparam int W  = q4se_pkg::WORD_BITS;
  localparam int OW = q4se_pkg::OP_BITS;

  q4se_pkg::cfg_t cfg;

  q4se_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // valid bits for stages 1 to 6; done serves as the valid bit of stage 7
  logic v1, v2, v3, v4, v5, v6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  // stage 1: edge offsets, outside test, nodal values
  logic                  out1;
  q4se_pkg::op_t         dbm1, dbp1, dhm1, dhp1;
  q4se_pkg::word_t       u1 [8];
  logic [W-1:0]          mx, my;
  logic                  out_next;

  always_comb begin
    mx = x_pos[W-1] ? W'(-x_pos) : W'(x_pos);
    my = y_pos[W-1] ? W'(-y_pos) : W'(y_pos);
    out_next = (mx > W'(cfg.half_width)) || (my > W'(cfg.half_height));
  end

  always_ff @(posedge clk) begin
    out1 <= out_next;
    dbm1 <= OW'($signed({1'b0, cfg.half_width}))  - OW'(x_pos);
    dbp1 <= OW'($signed({1'b0, cfg.half_width}))  + OW'(x_pos);
    dhm1 <= OW'($signed({1'b0, cfg.half_height})) - OW'(y_pos);
    dhp1 <= OW'($signed({1'b0, cfg.half_height})) + OW'(y_pos);
    u1[0] <= u1_x; u1[1] <= u1_y; u1[2] <= u2_x; u1[3] <= u2_y;
    u1[4] <= u3_x; u1[5] <= u3_y; u1[6] <= u4_x; u1[7] <= u4_y;
  end

  // stage 2: offset products with 1/(4bh), nodal differences
  // dif order: u2x-u1x, u3x-u4x, u4y-u1y, u3y-u2y, u4x-u1x, u3x-u2x, u2y-u1y, u3y-u4y
  logic            out2;
  q4se_pkg::op_t   inv_op;
  q4se_pkg::pp_t   pa2 [4];
  q4se_pkg::op_t   dhm2, dhp2;
  q4se_pkg::word_t u2 [8];
  q4se_pkg::op_t   dif2 [8];

  assign inv_op = OW'($signed({1'b0, cfg.inv_four_area}));

  always_ff @(posedge clk) begin
    out2    <= out1;
    pa2[0]  <= q4se_pkg::pmul(dbp1, inv_op);
    pa2[1]  <= q4se_pkg::pmul(dbm1, inv_op);
    pa2[2]  <= q4se_pkg::pmul(dhp1, inv_op);
    pa2[3]  <= q4se_pkg::pmul(dhm1, inv_op);
    dhm2    <= dhm1;
    dhp2    <= dhp1;
    u2      <= u1;
    dif2[0] <= OW'(u1[2]) - OW'(u1[0]);
    dif2[1] <= OW'(u1[4]) - OW'(u1[6]);
    dif2[2] <= OW'(u1[7]) - OW'(u1[1]);
    dif2[3] <= OW'(u1[5]) - OW'(u1[3]);
    dif2[4] <= OW'(u1[6]) - OW'(u1[0]);
    dif2[5] <= OW'(u1[4]) - OW'(u1[2]);
    dif2[6] <= OW'(u1[3]) - OW'(u1[1]);
    dif2[7] <= OW'(u1[5]) - OW'(u1[7]);
  end

  // stage 3: scaled offsets a1..a4
  logic            out3;
  q4se_pkg::word_t a1, a2, a3, a4;
  q4se_pkg::op_t   dhm3, dhp3;
  q4se_pkg::word_t u3 [8];
  q4se_pkg::op_t   dif3 [8];

  always_ff @(posedge clk) begin
    out3 <= out2;
    a1   <= q4se_pkg::rsat(q4se_pkg::psum(pa2[0]));
    a2   <= q4se_pkg::rsat(q4se_pkg::psum(pa2[1]));
    a3   <= q4se_pkg::rsat(q4se_pkg::psum(pa2[2]));
    a4   <= q4se_pkg::rsat(q4se_pkg::psum(pa2[3]));
    dhm3 <= dhm2;
    dhp3 <= dhp2;
    u3   <= u2;
    dif3 <= dif2;
  end

  // stage 4: shape function and strain products
  logic            out4;
  q4se_pkg::pp_t   pn4 [4];
  q4se_pkg::pp_t   pe4 [8];
  q4se_pkg::word_t u4 [8];

  always_ff @(posedge clk) begin
    out4   <= out3;
    u4     <= u3;
    pn4[0] <= q4se_pkg::pmul(dhm3, OW'(a2));
    pn4[1] <= q4se_pkg::pmul(dhm3, OW'(a1));
    pn4[2] <= q4se_pkg::pmul(dhp3, OW'(a1));
    pn4[3] <= q4se_pkg::pmul(dhp3, OW'(a2));
    pe4[0] <= q4se_pkg::pmul(OW'(a4), dif3[0]);
    pe4[1] <= q4se_pkg::pmul(OW'(a3), dif3[1]);
    pe4[2] <= q4se_pkg::pmul(OW'(a2), dif3[2]);
    pe4[3] <= q4se_pkg::pmul(OW'(a1), dif3[3]);
    pe4[4] <= q4se_pkg::pmul(OW'(a2), dif3[4]);
    pe4[5] <= q4se_pkg::pmul(OW'(a1), dif3[5]);
    pe4[6] <= q4se_pkg::pmul(OW'(a4), dif3[6]);
    pe4[7] <= q4se_pkg::pmul(OW'(a3), dif3[7]);
  end

  // stage 5: shape functions and strains
  logic            out5;
  q4se_pkg::word_t n1, n2, n3, n4, ex5, ey5, exy5;
  q4se_pkg::word_t u5 [8];

  always_ff @(posedge clk) begin
    out5 <= out4;
    u5   <= u4;
    n1   <= q4se_pkg::rsat(q4se_pkg::psum(pn4[0]));
    n2   <= q4se_pkg::rsat(q4se_pkg::psum(pn4[1]));
    n3   <= q4se_pkg::rsat(q4se_pkg::psum(pn4[2]));
    n4   <= q4se_pkg::rsat(q4se_pkg::psum(pn4[3]));
    ex5  <= q4se_pkg::rsat(q4se_pkg::psum(pe4[0]) + q4se_pkg::psum(pe4[1]));
    ey5  <= q4se_pkg::rsat(q4se_pkg::psum(pe4[2]) + q4se_pkg::psum(pe4[3]));
    exy5 <= q4se_pkg::rsat(q4se_pkg::psum(pe4[4]) + q4se_pkg::psum(pe4[5])
                         + q4se_pkg::psum(pe4[6]) + q4se_pkg::psum(pe4[7]));
  end

  // stage 6: displacement products (x terms 0..3, y terms 4..7) and stress products
  logic            out6;
  q4se_pkg::pp_t   pd6 [8];
  q4se_pkg::pp_t   ps6 [5];
  q4se_pkg::word_t ex6, ey6, exy6;

  always_ff @(posedge clk) begin
    out6   <= out5;
    ex6    <= ex5;
    ey6    <= ey5;
    exy6   <= exy5;
    pd6[0] <= q4se_pkg::pmul(OW'(n1), OW'(u5[0]));
    pd6[1] <= q4se_pkg::pmul(OW'(n2), OW'(u5[2]));
    pd6[2] <= q4se_pkg::pmul(OW'(n3), OW'(u5[4]));
    pd6[3] <= q4se_pkg::pmul(OW'(n4), OW'(u5[6]));
    pd6[4] <= q4se_pkg::pmul(OW'(n1), OW'(u5[1]));
    pd6[5] <= q4se_pkg::pmul(OW'(n2), OW'(u5[3]));
    pd6[6] <= q4se_pkg::pmul(OW'(n3), OW'(u5[5]));
    pd6[7] <= q4se_pkg::pmul(OW'(n4), OW'(u5[7]));
    ps6[0] <= q4se_pkg::pmul(OW'(cfg.c_normal), OW'(ex5));
    ps6[1] <= q4se_pkg::pmul(OW'(cfg.c_cross), OW'(ey5));
    ps6[2] <= q4se_pkg::pmul(OW'(cfg.c_cross), OW'(ex5));
    ps6[3] <= q4se_pkg::pmul(OW'(cfg.c_normal), OW'(ey5));
    ps6[4] <= q4se_pkg::pmul(OW'(cfg.c_shear), OW'(exy5));
  end

  // stage 7: displacement, stress; outside zeroes the result
  q4se_pkg::word_t dx_c, dy_c, sx_c, sy_c, sxy_c;

  always_comb begin
    dx_c  = q4se_pkg::rsat(q4se_pkg::psum(pd6[0]) + q4se_pkg::psum(pd6[1])
                         + q4se_pkg::psum(pd6[2]) + q4se_pkg::psum(pd6[3]));
    dy_c  = q4se_pkg::rsat(q4se_pkg::psum(pd6[4]) + q4se_pkg::psum(pd6[5])
                         + q4se_pkg::psum(pd6[6]) + q4se_pkg::psum(pd6[7]));
    sx_c  = q4se_pkg::rsat(q4se_pkg::psum(ps6[0]) + q4se_pkg::psum(ps6[1]));
    sy_c  = q4se_pkg::rsat(q4se_pkg::psum(ps6[2]) + q4se_pkg::psum(ps6[3]));
    sxy_c = q4se_pkg::rsat(q4se_pkg::psum(ps6[4]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v6;
    end
  end

  always_ff @(posedge clk) begin
    outside   <= out6;
    disp_x    <= out6 ? '0 : dx_c;
    disp_y    <= out6 ? '0 : dy_c;
    strain_x  <= out6 ? '0 : ex6;
    strain_y  <= out6 ? '0 : ey6;
    strain_xy <= out6 ? '0 : exy6;
    stress_x  <= out6 ? '0 : sx_c;
    stress_y  <= out6 ? '0 : sy_c;
    stress_xy <= out6 ? '0 : sxy_c;
  end

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##7 done) else $error("result strobe missing");
  a_zero_out: assert property (@(posedge clk) disable iff (rst)
    (done && outside) |-> (disp_x == '0 && strain_xy == '0 && stress_xy == '0))
    else $error("outside result not zeroed");
  a_no_ghost: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(v6)) else $error("result without request");
`endif

endmodule
